FILE: design/vts_pkg.sv
`default_nettype none
package vts_pkg;
  localparam int Depth = 64;
  localparam int ValueWidth = 32;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_SEARCH = 3'd1,
    REQ_DUMP   = 3'd2,
    REQ_RANGE  = 3'd3,
    REQ_SORTED = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [ValueWidth-1:0] value;
    logic [ValueWidth-1:0] range_low;
    logic [ValueWidth-1:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic [ValueWidth-1:0] out_value;
    logic [IdxW-1:0]       out_index;
    logic [1:0]            status;
    logic                  last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_EMIT,
    BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

FILE: design/vts_if.sv
`default_nettype none
interface vts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           req_type;
  logic signed [vts_pkg::ValueWidth-1:0] value;
  logic signed [vts_pkg::ValueWidth-1:0] range_low;
  logic signed [vts_pkg::ValueWidth-1:0] range_high;
  modport source (output valid, req_type, value, range_low, range_high, input ready);
  modport sink (input valid, req_type, value, range_low, range_high, output ready);
endinterface

interface vts_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vts_pkg::ValueWidth-1:0] out_value;
  logic [vts_pkg::IdxW-1:0]             out_index;
  logic [1:0]                           status;
  logic                                 last;
  modport source (output valid, out_value, out_index, status, last, input ready);
  modport sink (input valid, out_value, out_index, status, last, output ready);
endinterface
`default_nettype wire

FILE: design/vts_front.sv
`default_nettype none
module vts_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  vts_req_if.sink           in_ch,
  output vts_pkg::cmd_t     q_data,
  output logic              q_valid,
  input  wire logic         q_pop
);
  import vts_pkg::*;

  cmd_t             mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QCntW-1:0] cnt_r;
  logic             known;
  logic             push;

  assign known = (in_ch.req_type <= 3'(REQ_SORTED));
  assign in_ch.ready = (cnt_r != QCntW'(QDepth));
  assign push = in_ch.valid && in_ch.ready && known;
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{in_ch.req_type, in_ch.value, in_ch.range_low, in_ch.range_high};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPtrW'(1);
      if (q_pop) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + QCntW'(push) - QCntW'(q_pop);
    end
  end
endmodule
`default_nettype wire

FILE: design/vts_back.sv
`default_nettype none
module vts_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  vts_pkg::cmd_t     q_data,
  input  wire logic         q_valid,
  output logic              q_pop,
  vts_res_if.source         out_ch
);
  import vts_pkg::*;

  logic [ValueWidth-1:0] store_r [Depth];
  logic [CntW-1:0]       count_r;
  bk_state_t             st_r, st_nxt;
  cmd_t                  cmd_r;
  logic [CntW-1:0]       i_r;
  logic [ValueWidth-1:0] rd_r;
  logic [CntW-1:0]       emitted_r;
  // sorted dump: previous emitted key and index, best candidate so far
  logic [ValueWidth-1:0] pk_r;
  logic [IdxW-1:0]       pi_r;
  logic                  have_prev_r;
  logic [ValueWidth-1:0] bk_r;
  logic [ValueWidth-1:0] bv_r;
  logic [IdxW-1:0]       bi_r;
  logic                  have_best_r;
  // dump and range hold one pending result so the final one can carry last
  res_t                  pend_r;
  logic                  pend_v_r;
  res_t                  res_r;
  logic                  ov_r;

  logic [ValueWidth-1:0] msb;
  logic [ValueWidth-1:0] key, klo, khi;
  logic                  is_append, is_search, is_range, is_sorted;
  logic                  hit;
  logic                  after_prev, better;
  logic                  scan_over;
  logic                  out_free;
  logic                  emit_fire;
  logic                  last_round;
  logic [CntW-1:0]       i_inc, emitted_inc;
  res_t                  cur_res, emit_res, done_res;

  assign is_append = (cmd_r.req_type == 3'(REQ_APPEND));
  assign is_search = (cmd_r.req_type == 3'(REQ_SEARCH));
  assign is_range  = (cmd_r.req_type == 3'(REQ_RANGE));
  assign is_sorted = (cmd_r.req_type == 3'(REQ_SORTED));

  assign msb = {1'b1, {(ValueWidth-1){1'b0}}};
  assign key = rd_r ^ msb;
  assign klo = cmd_r.range_low ^ msb;
  assign khi = cmd_r.range_high ^ msb;
  assign hit = is_search ? (rd_r == cmd_r.value) :
               is_range  ? ((key >= klo) && (key <= khi)) : 1'b1;
  assign after_prev = !have_prev_r || key > pk_r ||
                      (key == pk_r && i_r[IdxW-1:0] > pi_r);
  assign better = !have_best_r || key < bk_r;
  assign scan_over = (i_r >= count_r);
  assign out_free = !ov_r || out_ch.ready;
  assign i_inc = i_r + CntW'(1);
  assign emitted_inc = emitted_r + CntW'(1);
  assign last_round = (emitted_inc >= count_r);
  assign emit_fire = out_free && (st_r == BK_EMIT || st_r == BK_DONE);

  always_comb begin
    cur_res = '0;
    cur_res.out_value = rd_r;
    cur_res.out_index = i_r[IdxW-1:0];
    cur_res.status = ST_OK;
  end

  // search hit, or the pending dump/range result that a newer hit pushes out
  always_comb begin
    emit_res = pend_r;
    if (is_search) begin
      emit_res = cur_res;
      emit_res.out_value = cmd_r.value;
      emit_res.last = 1'b1;
    end
  end

  // result at the end of a scan, or of an append
  always_comb begin
    done_res = '0;
    done_res.last = 1'b1;
    if (is_append) begin
      done_res.out_value = cmd_r.value;
      if (count_r >= CntW'(Depth)) begin
        done_res.status = ST_FULL;
      end else begin
        done_res.out_index = count_r[IdxW-1:0];
        done_res.status = ST_OK;
      end
    end else if (is_search) begin
      done_res.out_value = cmd_r.value;
      done_res.status = ST_NOTFOUND;
    end else if (is_sorted) begin
      if (have_best_r) begin
        done_res.out_value = bv_r;
        done_res.out_index = bi_r;
        done_res.status = ST_OK;
        done_res.last = last_round;
      end else begin
        done_res.status = ST_NONE;
      end
    end else begin
      if (pend_v_r) begin
        done_res = pend_r;
        done_res.last = 1'b1;
      end else begin
        done_res.status = ST_NONE;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) st_nxt = (q_data.req_type == 3'(REQ_APPEND)) ? BK_DONE : BK_READ;
      end
      BK_READ: st_nxt = scan_over ? BK_DONE : BK_EVAL;
      BK_EVAL: begin
        if (!is_sorted && hit && (is_search || pend_v_r)) st_nxt = BK_EMIT;
        else st_nxt = BK_READ;
      end
      BK_EMIT: begin
        if (out_free) st_nxt = is_search ? BK_IDLE : BK_READ;
      end
      BK_DONE: begin
        if (out_free) begin
          st_nxt = (is_sorted && have_best_r && !last_round) ? BK_READ : BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == BK_IDLE) && q_valid;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.out_value = res_r.out_value;
  assign out_ch.out_index = res_r.out_index;
  assign out_ch.status = res_r.status;
  assign out_ch.last = res_r.last;

  always_ff @(posedge clk) begin
    if (st_r == BK_READ) rd_r <= store_r[i_r[IdxW-1:0]];
    if (st_r == BK_DONE && out_free && is_append && count_r < CntW'(Depth)) begin
      store_r[count_r[IdxW-1:0]] <= cmd_r.value;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      res_r <= (st_r == BK_EMIT) ? emit_res : done_res;
    end
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          cmd_r <= q_data;
          i_r <= '0;
          emitted_r <= '0;
          have_prev_r <= 1'b0;
          have_best_r <= 1'b0;
          pend_v_r <= 1'b0;
        end
      end
      BK_EVAL: begin
        if (is_sorted) begin
          if (after_prev && better) begin
            bk_r <= key;
            bv_r <= rd_r;
            bi_r <= i_r[IdxW-1:0];
            have_best_r <= 1'b1;
          end
          i_r <= i_inc;
        end else if (!hit) begin
          i_r <= i_inc;
        end else if (!is_search && !pend_v_r) begin
          pend_r <= cur_res;
          pend_v_r <= 1'b1;
          i_r <= i_inc;
        end
      end
      BK_EMIT: begin
        if (out_free && !is_search) begin
          pend_r <= cur_res;
          i_r <= i_inc;
        end
      end
      BK_DONE: begin
        if (out_free && is_sorted) begin
          pk_r <= bk_r;
          pi_r <= bi_r;
          have_prev_r <= 1'b1;
          have_best_r <= 1'b0;
          emitted_r <= emitted_inc;
          i_r <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= emit_fire || (ov_r && !out_ch.ready);
      if (st_r == BK_DONE && out_free && is_append && count_r < CntW'(Depth)) begin
        count_r <= count_r + CntW'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/value_table_search_range_sort.sv
`default_nettype none
// channel   dir  fields
// in_ch     in   req_type value range_low range_high
// out_ch    out  out_value out_index status last
// a request is registered in the queue before the back end takes it; an append
// result passes through the queue, the done state and the output register
// scans step through the stored entries (registered read, then compare) and
// emit each result from its own state; a sorted dump makes one full scan for every result
// synchronous reset empties the table; stored values are not cleared
// a full output register holds the back end; the two-entry request queue
// keeps the input open until it fills
module value_table_search_range_sort (
  input  wire logic clk,
  input  wire logic rst_n,
  vts_req_if.sink   in_ch,
  vts_res_if.source out_ch
);
  import vts_pkg::*;

  cmd_t q_data;
  logic q_valid, q_pop;

  vts_front u_front (
    .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
  );

  vts_back u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .out_ch
  );
endmodule
`default_nettype wire
